[src/csma_pkg.sv]
package csma_pkg;

  localparam int unsigned PacketWordsDef = 16;
  localparam int unsigned WordBitsDef    = 32;
  localparam logic [7:0]  JamWord        = 8'd255;
  localparam int unsigned FrameOverhead  = 4;
  localparam int unsigned RandBits       = 10;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_LOAD   = 2'd1,
    OP_COMMIT = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    MODE_LISTEN = 3'd0,
    MODE_RECV   = 3'd1,
    MODE_SEND   = 3'd2,
    MODE_JAM    = 3'd3,
    MODE_BACKOFF = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_SENT     = 3'd1,
    EV_COLL     = 3'd2,
    EV_DELIVER  = 3'd3,
    EV_CORRUPT  = 3'd4,
    EV_BUSY     = 3'd5,
    EV_ACCEPTED = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_READ,
    CS_EMIT
  } ctl_state_e;

  localparam logic [2:0] CfgNodeId   = 3'd0;
  localparam logic [2:0] CfgStart    = 3'd1;
  localparam logic [2:0] CfgEnd      = 3'd2;
  localparam logic [2:0] CfgPktWords = 3'd3;
  localparam logic [2:0] CfgMaxExp   = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] bus_word;
    logic [9:0]  rand_bits;
    logic [3:0]  load_index;
    logic [31:0] load_word;
    logic [7:0]  dest_id;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] bus_drive;
    logic [2:0]  mac_mode;
    logic [2:0]  event_res;
    logic [15:0] retries;
    logic [31:0] frame_source;
    logic [3:0]  word_index;
    logic [31:0] payload_word;
    logic        last;
  } out_beat_t;

endpackage

[src/csma_cd_word_mac.sv]
// Word-wide CSMA/CD MAC. Each input beat is a bus tick (op 0), a payload load
// (op 1), a message commit (op 2) or a no-op (op 3). A beat is first accepted
// into a register while the transmit/receive word memories are read; then state
// is updated and the report is loaded into the output register, and no new beat
// is taken until that report has left the output register. A delivery then
// streams one payload word per cycle, while the output is not stalled, from the
// receive memory through its registered read port. After reset the transmit
// memory is swept clear before the first beat is taken; it is swept again after
// each successful send. The input channel is stalled during those sweeps and
// while results are pending.
module csma_cd_word_mac
  import csma_pkg::*;
#(
  parameter int unsigned PACKET_WORDS = PacketWordsDef,
  parameter int unsigned WORD_BITS    = WordBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_beat_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_beat_t  out_data_o
);

  localparam int unsigned AW = (PACKET_WORDS > 1) ? $clog2(PACKET_WORDS) : 1;
  localparam int unsigned PW = $clog2(PACKET_WORDS + 4);
  localparam logic [WORD_BITS-1:0] WMask = '1;

  // config
  logic [7:0]  node_id_q;
  logic [31:0] start_q, end_q;
  logic [4:0]  pkt_q;
  logic [3:0]  maxexp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q <= '0;
      start_q   <= 32'h95;
      end_q     <= 32'hba;
      pkt_q     <= 5'd10;
      maxexp_q  <= 4'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgNodeId:   node_id_q <= cfg_data_i[7:0];
        CfgStart:    start_q   <= cfg_data_i;
        CfgEnd:      end_q     <= cfg_data_i;
        CfgPktWords: pkt_q     <= cfg_data_i[4:0];
        CfgMaxExp:   maxexp_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  logic [PW-1:0] pw;
  always_comb begin
    if (pkt_q == 5'd0) pw = PW'(1);
    else if (32'(pkt_q) > PACKET_WORDS) pw = PW'(PACKET_WORDS);
    else pw = PW'(pkt_q);
  end

  logic [WORD_BITS-1:0] cmp_start, cmp_end;
  assign cmp_start = WORD_BITS'(start_q) & WMask;
  assign cmp_end   = WORD_BITS'(end_q) & WMask;

  // state
  ctl_state_e cs_q, cs_d;
  mode_e      mode_q;
  logic [PW-1:0]  pos_q;
  logic [14:0]    bo_q;
  logic [15:0]    retry_q;
  logic [7:0]     tx_tgt_q;
  logic           tx_wait_q;
  logic [WORD_BITS-1:0] drive_q, rx_src_q, rx_tgt_q;
  logic           clr_q;
  logic [AW:0]    clr_cnt_q;
  logic [AW:0]    dl_q;
  in_beat_t       beat_q;
  out_beat_t      out_q;
  logic           ov_q;

  // memories
  logic [WORD_BITS-1:0] tx_mem [PACKET_WORDS];
  logic [WORD_BITS-1:0] rx_mem [PACKET_WORDS];
  logic [WORD_BITS-1:0] tx_rd_q, rx_rd_q;
  logic           tx_we, rx_we;
  logic [AW-1:0]  tx_wa, rx_wa, tx_ra, rx_ra;
  logic [WORD_BITS-1:0] tx_wd, rx_wd;

  always_ff @(posedge clk_i) begin
    if (tx_we) tx_mem[tx_wa] <= tx_wd;
    if (rx_we) rx_mem[rx_wa] <= rx_wd;
    tx_rd_q <= tx_mem[tx_ra];
    rx_rd_q <= rx_mem[rx_ra];
  end

  logic accept, out_free;
  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = (cs_q != CS_IDLE) || clr_q || ov_q;
  assign accept     = in_valid_i && !in_stall_o;

  // read address: the next word to drive while sending, else delivery index
  logic [PW-1:0] nxt_pos;
  assign nxt_pos = pos_q + PW'(1);
  logic [PW:0] tx_off;
  assign tx_off = {1'b0, nxt_pos} - (PW + 1)'(3);
  always_comb begin
    tx_ra = tx_off[AW-1:0];
    // hold the current word while the output is blocked
    rx_ra = (dl_q != '0 && !out_free) ? AW'(dl_q - (AW + 1)'(1)) : dl_q[AW-1:0];
  end

  // update logic for a tick
  logic [WORD_BITS-1:0] bus;
  logic [14:0] bo_dec;
  assign bus    = WORD_BITS'(beat_q.bus_word) & WMask;
  assign bo_dec = (bo_q != '0) ? bo_q - 15'd1 : '0;

  logic [3:0]  exp_c;
  logic [16:0] e_full;
  logic [9:0]  rmask;
  logic [PW+10:0] wait_prod;
  logic [14:0] wait_sat;
  always_comb begin
    e_full = {1'b0, retry_q} + 17'd1;
    if (e_full > 17'(maxexp_q)) exp_c = maxexp_q;
    else exp_c = e_full[3:0];
    if (exp_c > 4'(RandBits)) exp_c = 4'(RandBits);
    rmask = 10'((11'd1 << exp_c) - 11'd1);
    wait_prod = (PW + 11)'(({1'b0, pw} + (PW + 1)'(FrameOverhead)))
              * (PW + 11)'(beat_q.rand_bits & rmask);
    wait_sat = (wait_prod > (PW + 11)'(15'h7FFF)) ? 15'h7FFF : wait_prod[14:0];
  end

  logic [WORD_BITS-1:0] tx_next;
  always_comb begin
    if (nxt_pos == PW'(1)) tx_next = WORD_BITS'(node_id_q);
    else if (nxt_pos == PW'(2)) tx_next = WORD_BITS'(tx_tgt_q);
    else if (tx_off < {1'b0, pw} && nxt_pos >= PW'(3)) tx_next = tx_rd_q;
    else tx_next = cmp_end;
  end

  // next control state
  always_comb begin
    cs_d = cs_q;
    unique case (cs_q)
      CS_IDLE: if (accept) cs_d = CS_READ;
      CS_READ: if (out_free) cs_d = CS_IDLE;
      CS_EMIT: if (out_free && dl_q == (AW + 1)'(pw)) cs_d = CS_IDLE;
      default: cs_d = CS_IDLE;
    endcase
  end

  mode_e mode_d;
  logic [PW-1:0] pos_d;
  logic [14:0] bo_d;
  logic [15:0] retry_d;
  logic [WORD_BITS-1:0] drive_d, rx_src_d, rx_tgt_d;
  logic tx_wait_d, start_clr, deliver;
  logic [7:0] tx_tgt_d;
  event_e ev;

  always_comb begin
    mode_d = mode_q; pos_d = pos_q; bo_d = bo_q; retry_d = retry_q;
    drive_d = drive_q; rx_src_d = rx_src_q; rx_tgt_d = rx_tgt_q;
    tx_wait_d = tx_wait_q; tx_tgt_d = tx_tgt_q;
    start_clr = 1'b0; deliver = 1'b0; ev = EV_NONE;
    rx_we = 1'b0; rx_wa = '0; rx_wd = bus;
    tx_we = 1'b0; tx_wa = beat_q.load_index[AW-1:0];
    tx_wd = WORD_BITS'(beat_q.load_word) & WMask;
    if (clr_q) begin
      tx_we = 1'b1; tx_wa = clr_cnt_q[AW-1:0]; tx_wd = '0;
    end else if (cs_q == CS_READ && out_free) begin
      unique case (op_e'(beat_q.op))
        OP_LOAD: begin
          if (tx_wait_q) ev = EV_BUSY;
          else begin
            ev = EV_ACCEPTED;
            tx_we = (32'(beat_q.load_index) < PACKET_WORDS);
          end
        end
        OP_COMMIT: begin
          if (tx_wait_q) ev = EV_BUSY;
          else begin
            ev = EV_ACCEPTED; tx_wait_d = 1'b1; tx_tgt_d = beat_q.dest_id;
          end
        end
        OP_NONE: ev = EV_NONE;
        OP_TICK: begin
          bo_d = bo_dec;
          unique case (mode_q)
            MODE_LISTEN: begin
              if (bus == cmp_start) begin
                mode_d = MODE_RECV; pos_d = '0;
              end else if (bus == '0 && tx_wait_q && bo_dec == '0) begin
                mode_d = MODE_SEND; pos_d = '0; drive_d = cmp_start;
              end
            end
            MODE_RECV: begin
              pos_d = nxt_pos;
              if (pos_q == '0) rx_src_d = bus;
              else if (pos_q == PW'(1)) rx_tgt_d = bus;
              else if ({1'b0, pos_q} < {1'b0, pw} + (PW + 1)'(2)) begin
                rx_we = 1'b1; rx_wa = AW'(pos_q - PW'(2));
              end else begin
                mode_d = MODE_LISTEN; pos_d = '0;
                if (bus == cmp_end) begin
                  if (rx_tgt_q == WORD_BITS'(node_id_q)) begin
                    deliver = 1'b1; ev = EV_DELIVER;
                  end
                end else ev = EV_CORRUPT;
              end
            end
            MODE_SEND: begin
              if (bus != drive_q) begin
                drive_d = WORD_BITS'(JamWord) & WMask; mode_d = MODE_JAM;
                pos_d = '0; ev = EV_COLL;
              end else if ({1'b0, pos_q} >= {1'b0, pw} + (PW + 1)'(3)) begin
                drive_d = '0; mode_d = MODE_LISTEN; pos_d = '0;
                start_clr = 1'b1; tx_wait_d = 1'b0; retry_d = '0; ev = EV_SENT;
              end else begin
                pos_d = nxt_pos; drive_d = tx_next;
              end
            end
            default: begin
              pos_d = nxt_pos;
              if (nxt_pos >= pw) begin
                bo_d = wait_sat;
                if (retry_q != 16'hFFFF) retry_d = retry_q + 16'd1;
                drive_d = '0; mode_d = MODE_LISTEN; pos_d = '0;
              end
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // report fields from the updated state
  logic [2:0] shown_d;
  assign shown_d = (mode_d == MODE_LISTEN && bo_d != '0) ? MODE_BACKOFF : mode_d;

  // a new beat enters the output register
  logic ov_set;
  assign ov_set = (cs_q == CS_READ && out_free) ||
                  (cs_q == CS_EMIT && out_free && dl_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q <= CS_IDLE; mode_q <= MODE_LISTEN; pos_q <= '0; bo_q <= '0;
      retry_q <= '0; drive_q <= '0; rx_src_q <= '0; rx_tgt_q <= '0;
      tx_wait_q <= 1'b0; tx_tgt_q <= '0; clr_q <= 1'b1; clr_cnt_q <= '0;
      dl_q <= '0; ov_q <= 1'b0; beat_q <= '0; out_q <= '0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + (AW + 1)'(1);
        if (clr_cnt_q == (AW + 1)'(PACKET_WORDS - 1)) clr_q <= 1'b0;
      end else if (start_clr) begin
        clr_q <= 1'b1; clr_cnt_q <= '0;
      end
      ov_q <= ov_set || (ov_q && out_stall_i);
      if (cs_q == CS_IDLE && accept) beat_q <= in_data_i;
      if (cs_q == CS_READ && out_free) begin
        mode_q <= mode_d; pos_q <= pos_d; bo_q <= bo_d; retry_q <= retry_d;
        drive_q <= drive_d; rx_src_q <= rx_src_d; rx_tgt_q <= rx_tgt_d;
        tx_wait_q <= tx_wait_d; tx_tgt_q <= tx_tgt_d;
        out_q <= '{kind: 1'b0, bus_drive: 32'(drive_d), mac_mode: shown_d,
                   event_res: ev, retries: retry_d, frame_source: '0,
                   word_index: '0, payload_word: '0, last: !deliver};
        dl_q <= '0;
        cs_q <= deliver ? CS_EMIT : cs_d;
      end else if (cs_q == CS_EMIT) begin
        // rx_rd_q holds word dl_q-1 once dl_q > 0
        if (out_free && dl_q != '0) begin
          out_q.kind <= 1'b1;
          out_q.frame_source <= 32'(rx_src_q);
          out_q.word_index <= 4'(dl_q - (AW + 1)'(1));
          out_q.payload_word <= 32'(rx_rd_q);
          out_q.last <= (dl_q == (AW + 1)'(pw));
        end
        if (dl_q == '0 || out_free) begin
          if (dl_q == (AW + 1)'(pw)) cs_q <= CS_IDLE;
          else dl_q <= dl_q + (AW + 1)'(1);
        end
      end else begin
        cs_q <= cs_d;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

[src/csma_chk.sv]
module csma_chk
  import csma_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_kind0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.kind |-> out_data_o.payload_word == '0)
    else $error("report carries payload");

  a_deliver_ev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind |-> out_data_o.event_res == EV_DELIVER)
    else $error("payload word without delivery event");

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken with result pending");

endmodule

bind csma_cd_word_mac csma_chk u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_stall_o(in_stall_o), .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i), .out_data_o(out_data_o)
);
